// ===== src/cipher_rotor_map_and_step_assert.svh =====
// Assertion macros used by the rotor top-level file.
`ifndef CIPHER_ROTOR_MAP_AND_STEP_ASSERT_SVH
`define CIPHER_ROTOR_MAP_AND_STEP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication under reset.
`define CRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotor assertion failed");
// Next-cycle implication under reset.
`define CRM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotor assertion failed");
`else
`define CRM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CRM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/crm_pkg.sv =====
// Types and constants shared by the rotor modules.
package crm_pkg;

    typedef logic [4:0] letter_t;

    // Operation codes
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_SETPOS = 3'd1;
    localparam logic [2:0] OP_STEP   = 3'd2;
    localparam logic [2:0] OP_FWD    = 3'd3;
    localparam logic [2:0] OP_BWD    = 3'd4;

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed
    {
        alu_op_t op;
        letter_t a;
        letter_t b;
    } alu_req_t;

    typedef struct packed
    {
        letter_t res;
        logic    wrap;
    } alu_rsp_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SETPOS,
        ST_STEP,
        ST_SHIFT,
        ST_FWD_READ,
        ST_FWD_SUB,
        ST_BWD_SCAN,
        ST_RESULT
    } state_t;

endpackage

// ===== src/crm_wiring.sv =====
// Wiring table memory: one write port, one registered read port.
module crm_wiring #(
    parameter int LETTERS = 26
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(LETTERS)-1:0]   wr_addr,
    input  crm_pkg::letter_t             wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(LETTERS)-1:0]   rd_addr,
    output crm_pkg::letter_t             rd_data
);
    import crm_pkg::*;

    letter_t mem [LETTERS];
    letter_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data valid next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/crm_modunit.sv =====
// Shared modular add/subtract unit with one conditional reduction.
module crm_modunit #(
    parameter int LETTERS = 26
) (
    input  crm_pkg::alu_req_t req,
    output crm_pkg::alu_rsp_t rsp
);
    import crm_pkg::*;

    localparam logic [5:0] L6 = 6'(LETTERS);

    logic [5:0] sum;

    // Form a + b or a + L - b, then subtract L once if it reached L
    always_comb
    begin
        case (req.op)
            ALU_SUB: sum = {1'b0, req.a} + L6 - {1'b0, req.b};
            default: sum = {1'b0, req.a} + {1'b0, req.b};
        endcase
        rsp.wrap = (sum >= L6);
        rsp.res  = rsp.wrap ? 5'(sum - L6) : sum[4:0];
    end

endmodule

// ===== src/cipher_rotor_map_and_step.sv =====
// Top level of the rotor: sequencer, position register and result register.
`include "cipher_rotor_map_and_step_assert.svh"

// One rotor of a rotor cipher with LETTERS wiring entries (2 to 32). Each input
// transfer carries one operation and yields exactly one result transfer. The
// block takes one item at a time: in_ready is high only while the sequencer is
// idle, and a finished result waits in the output register so the next item
// can be taken meanwhile. All letter arithmetic goes through one modular
// add/subtract unit, and the wiring table has a single registered read port.
// From accept, a load or an unknown code goes straight to the result state, as
// does a map with an out-of-range letter. A step passes through the step state;
// a set position stays in its state, subtracting LETTERS until the value is in range;
// a forward map passes through the shift, read and subtract states; a backward
// map shifts and then scans the table until a slot matches or every slot is
// checked. A result waits in the result state while the output register is full.
// The backward search reads one table entry per cycle through the read port.
module cipher_rotor_map_and_step #(
    parameter int LETTERS = 26
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       operation,
    input  logic [7:0]       letter_in,
    input  logic [4:0]       entry_index,
    input  logic [4:0]       entry_value,
    input  logic [4:0]       new_position,
    output logic             out_valid,
    input  logic             out_ready,
    output crm_pkg::letter_t letter_out,
    output logic             carry,
    output logic             invalid
);
    import crm_pkg::*;

    localparam int         IW   = $clog2(LETTERS);
    localparam logic [5:0] L6   = 6'(LETTERS);
    localparam logic [7:0] L8   = 8'(LETTERS);
    localparam logic [IW-1:0] LAST = IW'(LETTERS - 1);

    state_t        state_reg, state_next;
    letter_t       pos_reg, pos_next;
    letter_t       letter_reg, letter_next;
    letter_t       acc_reg, acc_next;
    logic          bwd_reg, bwd_next;
    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    letter_t       res_letter_reg, res_letter_next;
    logic          res_carry_reg, res_carry_next;
    logic          res_invalid_reg, res_invalid_next;
    logic          out_valid_reg, out_valid_next;
    letter_t       out_letter_reg, out_letter_next;
    logic          out_carry_reg, out_carry_next;
    logic          out_invalid_reg, out_invalid_next;

    logic          accept;
    logic          wr_en;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    letter_t       rd_data;
    alu_req_t      alu_req;
    alu_rsp_t      alu_rsp;
    logic          found;

    assign accept = in_valid && in_ready;
    assign wr_en  = accept && (operation == OP_LOAD) &&
                    ({1'b0, entry_index} < L6) && ({1'b0, entry_value} < L6);
    assign rd_en  = (state_reg == ST_FWD_READ) || (state_reg == ST_BWD_SCAN);
    assign rd_addr = (state_reg == ST_FWD_READ) ? acc_reg[IW-1:0] : scan_idx_reg;
    assign found  = cmp_vld_reg && (rd_data == acc_reg);

    crm_wiring #(
        .LETTERS (LETTERS)
    ) u_wiring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_index[IW-1:0]),
        .wr_data (entry_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crm_modunit #(
        .LETTERS (LETTERS)
    ) u_modunit (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Steer the shared unit by state
    always_comb
    begin
        unique case (state_reg)
            ST_SETPOS:   alu_req = '{op: ALU_ADD, a: acc_reg, b: 5'd0};
            ST_STEP:     alu_req = '{op: ALU_ADD, a: pos_reg, b: 5'd1};
            ST_SHIFT:    alu_req = '{op: ALU_ADD, a: letter_reg, b: pos_reg};
            ST_FWD_SUB:  alu_req = '{op: ALU_SUB, a: rd_data, b: pos_reg};
            ST_BWD_SCAN: alu_req = '{op: ALU_SUB, a: 5'(cmp_idx_reg), b: pos_reg};
            default:     alu_req = '{op: ALU_ADD, a: 5'd0, b: 5'd0};
        endcase
    end

    // Hold state, control and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            cmp_vld_reg   <= cmp_vld_next;
        end
    end

    // Hold working values and results
    always_ff @(posedge clk)
    begin
        letter_reg      <= letter_next;
        acc_reg         <= acc_next;
        bwd_reg         <= bwd_next;
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        res_letter_reg  <= res_letter_next;
        res_carry_reg   <= res_carry_next;
        res_invalid_reg <= res_invalid_next;
        out_letter_reg  <= out_letter_next;
        out_carry_reg   <= out_carry_next;
        out_invalid_reg <= out_invalid_next;
    end

    // Sequence one operation
    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        letter_next      = letter_reg;
        acc_next         = acc_reg;
        bwd_next         = bwd_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        res_letter_next  = res_letter_reg;
        res_carry_next   = res_carry_reg;
        res_invalid_next = res_invalid_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_letter_next  = out_letter_reg;
        out_carry_next   = out_carry_reg;
        out_invalid_next = out_invalid_reg;
        in_ready         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    res_letter_next  = '0;
                    res_carry_next   = 1'b0;
                    res_invalid_next = 1'b0;
                    letter_next      = letter_in[4:0];
                    acc_next         = new_position;
                    bwd_next         = (operation == OP_BWD);
                    unique case (operation) inside
                        OP_SETPOS: state_next = ST_SETPOS;
                        OP_STEP:   state_next = ST_STEP;
                        OP_FWD, OP_BWD:
                        begin
                            if (letter_in >= L8)
                            begin
                                res_invalid_next = 1'b1;
                                state_next       = ST_RESULT;
                            end
                            else
                            begin
                                state_next = ST_SHIFT;
                            end
                        end
                        default:   state_next = ST_RESULT;
                    endcase
                end
            end

            ST_SETPOS:
            begin
                // Subtract LETTERS until the value is in range
                if (alu_rsp.wrap)
                begin
                    acc_next = alu_rsp.res;
                end
                else
                begin
                    pos_next   = acc_reg;
                    state_next = ST_RESULT;
                end
            end

            ST_STEP:
            begin
                pos_next       = alu_rsp.res;
                res_carry_next = alu_rsp.wrap;
                state_next     = ST_RESULT;
            end

            ST_SHIFT:
            begin
                acc_next      = alu_rsp.res;
                scan_idx_next = '0;
                cmp_vld_next  = 1'b0;
                state_next    = bwd_reg ? ST_BWD_SCAN : ST_FWD_READ;
            end

            ST_FWD_READ:
            begin
                state_next = ST_FWD_SUB;
            end

            ST_FWD_SUB:
            begin
                res_letter_next = alu_rsp.res;
                state_next      = ST_RESULT;
            end

            ST_BWD_SCAN:
            begin
                // Compare the entry read last cycle, issue the next read
                if (found)
                begin
                    res_letter_next = alu_rsp.res;
                    cmp_vld_next    = 1'b0;
                    state_next      = ST_RESULT;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LAST))
                begin
                    res_invalid_next = 1'b1;
                    cmp_vld_next     = 1'b0;
                    state_next       = ST_RESULT;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx_reg;
                    if (scan_idx_reg != LAST)
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            ST_RESULT:
            begin
                // Move the result into the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_letter_next  = res_letter_reg;
                    out_carry_next   = res_carry_reg;
                    out_invalid_next = res_invalid_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign letter_out = out_letter_reg;
    assign carry      = out_carry_reg;
    assign invalid    = out_invalid_reg;

    `CRM_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, {1'b0, pos_reg} < L6)
    `CRM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, !in_ready)
    `CRM_ASSERT_IMP(a_cmp_idx_range, clk, rst_n, cmp_vld_reg,
                    {{(6-IW){1'b0}}, cmp_idx_reg} < L6)
    `CRM_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_valid && invalid,
                    (letter_out == 5'd0) && !carry)
    `CRM_ASSERT_NXT(a_result_holds, clk, rst_n,
                    (state_reg == ST_RESULT) && out_valid_reg && !out_ready,
                    state_reg == ST_RESULT)

endmodule
